/* rtl/core/klbc_pkg.sv */
package klbc_pkg;

   localparam int SEED_W   = 64;
   localparam int DBL_W    = 64;
   localparam int DRAWS_W  = 24;
   localparam int COUNT_W  = 48;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 2;
   localparam int CSR_IDX_W = 1;

   localparam logic [STATUS_W-1:0] ST_HIT    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISS   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DRAWS   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHARE_DRAWS = 1'b1;

   localparam logic [DRAWS_W-1:0] MIN_DRAWS_RESET   = 24'd1024;
   localparam logic [DRAWS_W-1:0] SHARE_DRAWS_RESET = 24'd4096;

   localparam logic [DBL_W-1:0] ABS_MASK = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [DBL_W-1:0] EXP_ONES = 64'h7FF0_0000_0000_0000;

   typedef struct packed {
      logic [SEED_W-1:0] seed;
      logic [DBL_W-1:0]  correlation;
      logic [DBL_W-1:0]  threshold;
      logic [DBL_W-1:0]  tail_scl;
      logic [DBL_W-1:0]  stress_scl;
      logic              stress_flag;
   } key_type;

   typedef struct packed {
      logic same;
      logic hit;
   } match_type;

   // Doubles compare by value: the two zeros match and a NaN matches nothing.
   function automatic logic dbl_same(input logic [DBL_W-1:0] a, input logic [DBL_W-1:0] b);
      logic [DBL_W-1:0] a_abs;
      logic [DBL_W-1:0] b_abs;
      a_abs = a & ABS_MASK;
      b_abs = b & ABS_MASK;
      if ((a_abs > EXP_ONES) || (b_abs > EXP_ONES)) begin
         dbl_same = 1'b0;
      end else if ((a_abs == '0) && (b_abs == '0)) begin
         dbl_same = 1'b1;
      end else begin
         dbl_same = (a == b);
      end
   endfunction

endpackage

/* rtl/core/klbc_match.sv */
module klbc_match
   import klbc_pkg::*;
(
   input  logic               entry_valid,
   input  key_type            entry_key,
   input  logic [DRAWS_W-1:0] entry_draws,
   input  key_type            req_key,
   input  logic [DRAWS_W-1:0] need_draws,
   output match_type          match
);

   logic key_same;

   assign key_same = (entry_key.seed == req_key.seed)
                  && dbl_same(entry_key.correlation, req_key.correlation)
                  && dbl_same(entry_key.threshold, req_key.threshold)
                  && dbl_same(entry_key.tail_scl, req_key.tail_scl)
                  && dbl_same(entry_key.stress_scl, req_key.stress_scl)
                  && (entry_key.stress_flag == req_key.stress_flag);

   assign match.same = entry_valid && key_same;
   assign match.hit  = entry_valid && key_same && (entry_draws >= need_draws);

endmodule

/* rtl/core/klbc_lru.sv */
module klbc_lru
   import klbc_pkg::*;
#(
   parameter int WAYS = 4
) (
   input  logic [COUNT_W-1:0]      last_use [WAYS],
   output logic [$clog2(WAYS)-1:0] victim
);

   localparam int IDX_W = $clog2(WAYS);

   logic [COUNT_W-1:0] best_stamp;

   // Strict compare keeps the lowest index when stamps tie.
   always_comb begin
      victim     = '0;
      best_stamp = last_use[0];
      for (int i = 1; i < WAYS; i++) begin
         if (last_use[i] < best_stamp) begin
            victim     = IDX_W'(i);
            best_stamp = last_use[i];
         end
      end
   end

endmodule

/* rtl/core/keyed_lru_bank_cache.sv */
// Keyed LRU bank cache.
// A request transfer on req_* carries a key (seed, four IEEE double patterns,
// stress flag) and a draw count; each request produces exactly one response
// on rsp_*, in order, with status hit, miss or rejected count, the slot, the
// bank identity, the bank draw count and the running hit and generation totals.
// csr_* writes the two window registers; csr_ready is always high and writes
// are expected only while no request is in flight.
// A request accepted at a rising edge is registered, looked up against all
// ways in parallel and written into the response register once that register
// is free; rsp_tvalid then rises. Throughput: one request per cycle while the
// receiver takes responses; the four-way key compare and the LRU victim
// search both sit in the single stage between the two registers.
// Reset clears every way's valid bit, the counters (identity restarts at one)
// and loads the window registers with 1024 and 4096.
// When the receiver stalls, the response register holds, the request register
// fills behind it and req_tready then drops until the response is taken.
module keyed_lru_bank_cache
   import klbc_pkg::*;
#(
   parameter int WAYS = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   // seed[63:0], correlation_bits[127:64], threshold_bits[191:128],
   // tail scale bits[255:192], stress scale bits[319:256], draw_count[343:320]
   input  logic [343:0]          req_tdata,
   // stress_flag[0]
   input  logic                  req_tuser,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // slot[1:0], bank_identity[49:2], bank_draw_count[73:50], hit_total[121:74],
   // generation_total[169:122], zero fill[175:170]
   output logic [175:0]          rsp_tdata,
   // status[1:0]
   output logic [STATUS_W-1:0]   rsp_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [DRAWS_W-1:0]    csr_data
);

   localparam int IDX_W = $clog2(WAYS);

   // Configuration
   logic [DRAWS_W-1:0] min_draws_ff;
   logic [DRAWS_W-1:0] share_draws_ff;

   // Request register
   logic               in_valid_ff;
   key_type            in_key_ff;
   logic [DRAWS_W-1:0] in_draws_ff;

   // Cache state
   logic [WAYS-1:0]    valid_ff;
   key_type            entry_key_ff      [WAYS];
   logic [DRAWS_W-1:0] entry_draws_ff    [WAYS];
   logic [COUNT_W-1:0] entry_identity_ff [WAYS];
   logic [COUNT_W-1:0] entry_last_use_ff [WAYS];
   logic [COUNT_W-1:0] use_clock_ff;
   logic [COUNT_W-1:0] next_id_ff;
   logic [COUNT_W-1:0] hit_count_ff;
   logic [COUNT_W-1:0] gen_count_ff;

   // Response register
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [COUNT_W-1:0]  rsp_identity_ff;
   logic [DRAWS_W-1:0]  rsp_draws_ff;
   logic [COUNT_W-1:0]  rsp_hit_total_ff;
   logic [COUNT_W-1:0]  rsp_gen_total_ff;

   logic               req_fire;
   logic               out_free;
   logic               advance;
   logic               reject;
   logic [DRAWS_W-1:0] bank;
   match_type          match [WAYS];
   logic               hit_any;
   logic [IDX_W-1:0]   hit_idx;
   logic               same_any;
   logic [IDX_W-1:0]   same_idx;
   logic               free_any;
   logic [IDX_W-1:0]   free_idx;
   logic [IDX_W-1:0]   lru_idx;
   logic [IDX_W-1:0]   target;
   logic [COUNT_W-1:0] use_clock_in;
   logic [COUNT_W-1:0] next_id_in;
   logic [COUNT_W-1:0] hit_count_in;
   logic [COUNT_W-1:0] gen_count_in;

   assign csr_ready = 1'b1;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_draws_ff   <= MIN_DRAWS_RESET;
         share_draws_ff <= SHARE_DRAWS_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MIN_DRAWS:   min_draws_ff   <= csr_data;
            CSR_SHARE_DRAWS: share_draws_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_fire) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_key_ff.seed        <= req_tdata[63:0];
         in_key_ff.correlation <= req_tdata[127:64];
         in_key_ff.threshold   <= req_tdata[191:128];
         in_key_ff.tail_scl    <= req_tdata[255:192];
         in_key_ff.stress_scl  <= req_tdata[319:256];
         in_key_ff.stress_flag <= req_tuser;
         in_draws_ff           <= req_tdata[343:320];
      end
   end

   // Counts inside the window round up to the shared bank; an empty window
   // never matches.
   assign reject = (in_draws_ff == '0);
   assign bank   = ((in_draws_ff >= min_draws_ff) && (in_draws_ff <= share_draws_ff))
                   ? share_draws_ff : in_draws_ff;

   for (genvar g = 0; g < WAYS; g++) begin : g_way
      klbc_match u_match (
         .entry_valid (valid_ff[g]),
         .entry_key   (entry_key_ff[g]),
         .entry_draws (entry_draws_ff[g]),
         .req_key     (in_key_ff),
         .need_draws  (bank),
         .match       (match[g])
      );
   end

   klbc_lru #(.WAYS(WAYS)) u_lru (
      .last_use (entry_last_use_ff),
      .victim   (lru_idx)
   );

   // Lowest index wins in every search. Ways fill in order, so the first
   // free way equals the fill count.
   always_comb begin
      hit_any  = 1'b0;
      hit_idx  = '0;
      same_any = 1'b0;
      same_idx = '0;
      free_any = 1'b0;
      free_idx = '0;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (match[i].hit) begin
            hit_any = 1'b1;
            hit_idx = IDX_W'(i);
         end
         if (match[i].same) begin
            same_any = 1'b1;
            same_idx = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      if (same_any) begin
         target = same_idx;
      end else if (free_any) begin
         target = free_idx;
      end else begin
         target = lru_idx;
      end
   end

   assign use_clock_in = use_clock_ff + 1'b1;
   assign next_id_in   = next_id_ff + 1'b1;
   assign hit_count_in = hit_count_ff + 1'b1;
   assign gen_count_in = gen_count_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         use_clock_ff <= '0;
         next_id_ff   <= COUNT_W'(1);
         hit_count_ff <= '0;
         gen_count_ff <= '0;
      end else if (advance && !reject) begin
         use_clock_ff <= use_clock_in;
         if (hit_any) begin
            hit_count_ff <= hit_count_in;
         end else begin
            gen_count_ff     <= gen_count_in;
            next_id_ff       <= next_id_in;
            valid_ff[target] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && !reject) begin
         if (hit_any) begin
            entry_last_use_ff[hit_idx] <= use_clock_in;
         end else begin
            if (!same_any) begin
               entry_key_ff[target] <= in_key_ff;
            end
            entry_draws_ff[target]    <= bank;
            entry_identity_ff[target] <= next_id_ff;
            entry_last_use_ff[target] <= use_clock_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (reject) begin
            rsp_status_ff    <= ST_REJECT;
            rsp_slot_ff      <= '0;
            rsp_identity_ff  <= '0;
            rsp_draws_ff     <= '0;
            rsp_hit_total_ff <= hit_count_ff;
            rsp_gen_total_ff <= gen_count_ff;
         end else if (hit_any) begin
            rsp_status_ff    <= ST_HIT;
            rsp_slot_ff      <= SLOT_W'(hit_idx);
            rsp_identity_ff  <= entry_identity_ff[hit_idx];
            rsp_draws_ff     <= entry_draws_ff[hit_idx];
            rsp_hit_total_ff <= hit_count_in;
            rsp_gen_total_ff <= gen_count_ff;
         end else begin
            rsp_status_ff    <= ST_MISS;
            rsp_slot_ff      <= SLOT_W'(target);
            rsp_identity_ff  <= next_id_ff;
            rsp_draws_ff     <= bank;
            rsp_hit_total_ff <= hit_count_ff;
            rsp_gen_total_ff <= gen_count_in;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {6'd0, rsp_gen_total_ff, rsp_hit_total_ff, rsp_draws_ff,
                        rsp_identity_ff, rsp_slot_ff};

   // Ways are filled strictly in index order.
   assert property (@(posedge clock) disable iff (reset)
      ((valid_ff & (valid_ff + 1'b1)) == '0))
      else $error("cache valid bits are not a contiguous run from way zero");

   // A rejected count reports no slot, identity or draw count.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_REJECT)) |->
         ((rsp_slot_ff == '0) && (rsp_identity_ff == '0) && (rsp_draws_ff == '0)))
      else $error("rejected response carries nonzero payload");

   // Every miss counts one generation and consumes one identity.
   assert property (@(posedge clock) disable iff (reset)
      (advance && !reject && !hit_any) |=>
         ((gen_count_ff == $past(gen_count_in)) && (rsp_status_ff == ST_MISS)
          && (rsp_identity_ff == $past(next_id_ff))))
      else $error("miss did not advance generation count and identity");

   // A hit never returns an empty bank.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_HIT)) |-> (rsp_draws_ff != '0))
      else $error("hit response with zero bank draws");

endmodule
